// ===== design/pcf_pkg.sv =====
package pcf_pkg;

   localparam int SAMPLE_WIDTH         = 16;
   localparam int DIFF_W               = SAMPLE_WIDTH + 1;
   localparam int ANGLE_W              = 17;
   localparam int ANGLE_MAX            = 46080;
   localparam int GAIN_W               = 24;
   localparam int CORDIC_STEPS_DEFAULT = 16;
   localparam int TABLE_LEN            = 24;
   localparam int TABLE_IDX_W          = 5;
   // CORDIC x/y: sample shifted up by 8, times sqrt(2) and CORDIC gain, plus margin
   localparam int XY_W                 = SAMPLE_WIDTH + 12;
   // angle accumulator in 1/65536 degree
   localparam int Z_W                  = 26;
   localparam int CSR_IDX_W            = 2;
   localparam int CSR_DATA_W           = 24;

   localparam logic [GAIN_W-1:0]       GAIN_RESET     = GAIN_W'(65536);
   localparam logic signed [Z_W-1:0]   HALF_TURN_FINE = Z_W'(11796480);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ACCEL_X_OFFSET = 2'd0,
      CSR_GYRO_Y_OFFSET  = 2'd1,
      CSR_GYRO_STEP_GAIN = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] accel_x_offset;
      logic signed [SAMPLE_WIDTH-1:0] gyro_y_offset;
      logic [GAIN_W-1:0]              gyro_step_gain;
   } pcf_cfg_type;

   typedef struct packed {
      logic busy;
      logic done;
   } pcf_cordic_status_type;

   // atan(2^-i) in 1/65536 degree, rounded to nearest
   function automatic logic signed [Z_W-1:0] atan_fine(input logic [TABLE_IDX_W-1:0] idx);
      logic signed [Z_W-1:0] val;
      case (idx)
         5'd0:    val = Z_W'(2949120);
         5'd1:    val = Z_W'(1740967);
         5'd2:    val = Z_W'(919879);
         5'd3:    val = Z_W'(466945);
         5'd4:    val = Z_W'(234379);
         5'd5:    val = Z_W'(117304);
         5'd6:    val = Z_W'(58666);
         5'd7:    val = Z_W'(29335);
         5'd8:    val = Z_W'(14668);
         5'd9:    val = Z_W'(7334);
         5'd10:   val = Z_W'(3667);
         5'd11:   val = Z_W'(1833);
         5'd12:   val = Z_W'(917);
         5'd13:   val = Z_W'(458);
         5'd14:   val = Z_W'(229);
         5'd15:   val = Z_W'(115);
         5'd16:   val = Z_W'(57);
         5'd17:   val = Z_W'(29);
         5'd18:   val = Z_W'(14);
         5'd19:   val = Z_W'(7);
         5'd20:   val = Z_W'(4);
         5'd21:   val = Z_W'(2);
         5'd22:   val = Z_W'(1);
         default: val = '0;
      endcase
      return val;
   endfunction

   // clamp to +-180 degrees in 1/256 degree
   function automatic logic signed [ANGLE_W-1:0] sat_angle(input logic signed [31:0] v);
      logic signed [ANGLE_W-1:0] res;
      if (v > 32'sd46080) begin
         res = ANGLE_W'(ANGLE_MAX);
      end else if (v < -32'sd46080) begin
         res = ANGLE_W'(-ANGLE_MAX);
      end else begin
         res = v[ANGLE_W-1:0];
      end
      return res;
   endfunction

endpackage

// ===== design/pcf_csr.sv =====
module pcf_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pcf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pcf_pkg::CSR_DATA_W-1:0]    csr_data,
   output pcf_pkg::pcf_cfg_type              cfg
);

   pcf_pkg::pcf_cfg_type cfg_ff;
   pcf_pkg::pcf_cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            pcf_pkg::CSR_ACCEL_X_OFFSET: begin
               cfg_in.accel_x_offset = csr_data[pcf_pkg::SAMPLE_WIDTH-1:0];
            end
            pcf_pkg::CSR_GYRO_Y_OFFSET: begin
               cfg_in.gyro_y_offset = csr_data[pcf_pkg::SAMPLE_WIDTH-1:0];
            end
            pcf_pkg::CSR_GYRO_STEP_GAIN: begin
               cfg_in.gyro_step_gain = csr_data[pcf_pkg::GAIN_W-1:0];
            end
            default: begin
               // drop writes outside the register list
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.accel_x_offset <= '0;
         cfg_ff.gyro_y_offset  <= '0;
         cfg_ff.gyro_step_gain <= pcf_pkg::GAIN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== design/pcf_cordic.sv =====
module pcf_cordic #(
   parameter int CORDIC_STEPS = pcf_pkg::CORDIC_STEPS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic signed [pcf_pkg::DIFF_W-1:0]      ax,
   input  logic signed [pcf_pkg::SAMPLE_WIDTH-1:0] az,
   output pcf_pkg::pcf_cordic_status_type         status,
   output logic signed [pcf_pkg::ANGLE_W-1:0]     angle
);

   localparam int XY_W   = pcf_pkg::XY_W;
   localparam int Z_W    = pcf_pkg::Z_W;
   localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);
   localparam logic signed [Z_W-1:0] Z_ROUND = Z_W'(128);

   typedef enum logic [2:0] {
      CS_IDLE = 3'b001,
      CS_ITER = 3'b010,
      CS_DONE = 3'b100
   } cordic_state_type;

   cordic_state_type       state_ff, state_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic signed [XY_W-1:0] x_ff, x_in;
   logic signed [XY_W-1:0] y_ff, y_in;
   logic signed [Z_W-1:0]  z_ff, z_in;
   logic                   zero_ff, zero_in;

   logic signed [XY_W-1:0] x_load, y_load;
   logic signed [Z_W-1:0]  z_load;
   logic signed [XY_W-1:0] x_shift, y_shift;
   logic signed [Z_W-1:0]  atan_step;
   logic signed [Z_W-1:0]  z_round;

   // pre-rotate into the right half plane
   always_comb begin
      x_load = XY_W'(az) <<< 8;
      y_load = -(XY_W'(ax) <<< 8);
      z_load = '0;
      if (x_load[XY_W-1]) begin
         z_load = y_load[XY_W-1] ? -pcf_pkg::HALF_TURN_FINE : pcf_pkg::HALF_TURN_FINE;
         x_load = -x_load;
         y_load = -y_load;
      end
   end

   assign x_shift   = x_ff >>> step_ff;
   assign y_shift   = y_ff >>> step_ff;
   assign atan_step = pcf_pkg::atan_fine(pcf_pkg::TABLE_IDX_W'(step_ff));

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      zero_in  = zero_ff;
      case (state_ff)
         CS_IDLE: begin
            if (start) begin
               x_in     = x_load;
               y_in     = y_load;
               z_in     = z_load;
               zero_in  = (ax == '0) && (az == '0);
               step_in  = '0;
               state_in = CS_ITER;
            end
         end
         CS_ITER: begin
            // rotate toward y = 0
            if (!y_ff[XY_W-1]) begin
               x_in = x_ff + y_shift;
               y_in = y_ff - x_shift;
               z_in = z_ff + atan_step;
            end else begin
               x_in = x_ff - y_shift;
               y_in = y_ff + x_shift;
               z_in = z_ff - atan_step;
            end
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = CS_DONE;
            end
         end
         CS_DONE: begin
            state_in = CS_IDLE;
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
      step_ff <= step_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      zero_ff <= zero_in;
   end

   // round half up from 1/65536 to 1/256 degree
   assign z_round     = (z_ff + Z_ROUND) >>> 8;
   assign angle       = zero_ff ? '0 : pcf_pkg::sat_angle(32'(z_round));
   assign status.busy = (state_ff != CS_IDLE);
   assign status.done = (state_ff == CS_DONE);

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> (state_ff == CS_IDLE))
      else $error("cordic started while busy");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == CS_ITER) |-> (step_ff <= LAST_STEP))
      else $error("cordic step counter past last step");

   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      status.done |=> (state_ff == CS_IDLE))
      else $error("cordic did not return to idle after done");

endmodule

// ===== design/pitch_complementary_filter.sv =====
// Pitch estimator: complementary filter of accelerometer tilt and gyro rate.
// Request channel (req_valid / req_stall): one transaction carries raw
// accel X, accel Z and gyro Y samples; it is taken when req_valid is high
// and req_stall is low. req_stall stays high while a sample set is in work.
// Response channel (rsp_valid / rsp_stall): one transaction per request
// with fused, observed and gyro-estimated pitch in 1/256 degree.
// Config channel (csr_valid / csr_ready): index 0 accel X offset, 1 gyro Y
// offset, 2 gyro step gain; other indexes are ignored. csr_ready is always
// high. Write only while no request is in work.
// An accepted request passes through ST_CORDIC, ST_EST and ST_FUSE before
// rsp_valid rises; the next request is taken only once ST_FUSE is left.
// The CORDIC is a single shift-add unit that does one rotation a cycle.
// A stalled response holds in the output register; the next request is
// still accepted and runs until its result needs that register.
// Reset (synchronous, active high) clears the stored pitch and the offsets,
// sets the gain to 65536 and empties the response register.
module pitch_complementary_filter #(
   parameter int CORDIC_STEPS = pcf_pkg::CORDIC_STEPS_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // request channel
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [pcf_pkg::SAMPLE_WIDTH-1:0] req_accel_x,
   input  logic signed [pcf_pkg::SAMPLE_WIDTH-1:0] req_accel_z,
   input  logic signed [pcf_pkg::SAMPLE_WIDTH-1:0] req_gyro_y,
   // response channel
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [pcf_pkg::ANGLE_W-1:0]      rsp_pitch_angle,
   output logic signed [pcf_pkg::ANGLE_W-1:0]      rsp_observed_angle,
   output logic signed [pcf_pkg::ANGLE_W-1:0]      rsp_estimated_angle,
   // configuration channel
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [pcf_pkg::CSR_IDX_W-1:0]           csr_index,
   input  logic [pcf_pkg::CSR_DATA_W-1:0]          csr_data
);

   localparam int DIFF_W  = pcf_pkg::DIFF_W;
   localparam int ANGLE_W = pcf_pkg::ANGLE_W;
   localparam int GAIN_W  = pcf_pkg::GAIN_W;
   localparam int PROD_W  = DIFF_W + GAIN_W + 1;
   localparam int DELTA_W = PROD_W - GAIN_W;
   localparam logic signed [PROD_W-1:0] PROD_HALF = PROD_W'(1) <<< (GAIN_W - 1);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_CORDIC = 4'b0010,
      ST_EST    = 4'b0100,
      ST_FUSE   = 4'b1000
   } filter_state_type;

   pcf_pkg::pcf_cfg_type           cfg;
   pcf_pkg::pcf_cordic_status_type cordic_status;
   logic signed [ANGLE_W-1:0]      cordic_angle;

   filter_state_type          state_ff, state_in;
   logic signed [ANGLE_W-1:0] pitch_ff, pitch_in;
   logic signed [DIFF_W-1:0]  gy_ff, gy_in;
   logic signed [PROD_W-1:0]  product_ff, product_in;
   logic signed [ANGLE_W-1:0] obs_ff, obs_in;
   logic signed [ANGLE_W-1:0] est_ff, est_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [ANGLE_W-1:0] rsp_pitch_ff, rsp_pitch_in;
   logic signed [ANGLE_W-1:0] rsp_obs_ff, rsp_obs_in;
   logic signed [ANGLE_W-1:0] rsp_est_ff, rsp_est_in;

   logic                      req_accept;
   logic                      out_free;
   logic signed [DIFF_W-1:0]  ax_diff;
   logic signed [GAIN_W:0]    gain_signed;
   logic signed [PROD_W-1:0]  product_round;
   logic signed [DELTA_W-1:0] delta;
   logic signed [ANGLE_W-1:0] est_sat;
   logic signed [31:0]        fuse_sum;
   logic signed [ANGLE_W-1:0] fused;

   pcf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // offset-corrected samples are exact in one extra bit
   assign ax_diff = DIFF_W'(req_accel_x) - DIFF_W'(cfg.accel_x_offset);
   assign gy_in   = req_accept ? (DIFF_W'(req_gyro_y) - DIFF_W'(cfg.gyro_y_offset)) : gy_ff;

   pcf_cordic #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock  (clock),
      .reset  (reset),
      .start  (req_accept),
      .ax     (ax_diff),
      .az     (req_accel_z),
      .status (cordic_status),
      .angle  (cordic_angle)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   // response register can take a new result this cycle
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // gyro step: gy * gain / 2^24, round half up; product settles during the CORDIC
   assign gain_signed   = {1'b0, cfg.gyro_step_gain};
   assign product_in    = gy_ff * gain_signed;
   assign product_round = product_ff + PROD_HALF;
   assign delta         = product_round[PROD_W-1:GAIN_W];
   assign est_sat       = pcf_pkg::sat_angle(32'(pitch_ff) + 32'(delta));

   // blend: mean of observed and estimated, round half up
   assign fuse_sum = 32'(obs_ff) + 32'(est_ff) + 32'sd1;
   assign fused    = pcf_pkg::sat_angle(fuse_sum >>> 1);

   always_comb begin
      state_in     = state_ff;
      pitch_in     = pitch_ff;
      obs_in       = obs_ff;
      est_in       = est_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_pitch_in = rsp_pitch_ff;
      rsp_obs_in   = rsp_obs_ff;
      rsp_est_in   = rsp_est_ff;

      // retire the pending response once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_CORDIC;
            end
         end
         ST_CORDIC: begin
            if (cordic_status.done) begin
               obs_in   = cordic_angle;
               state_in = ST_EST;
            end
         end
         ST_EST: begin
            est_in   = est_sat;
            state_in = ST_FUSE;
         end
         ST_FUSE: begin
            // hold until the response register frees up
            if (out_free) begin
               pitch_in     = fused;
               rsp_valid_in = 1'b1;
               rsp_pitch_in = fused;
               rsp_obs_in   = obs_ff;
               rsp_est_in   = est_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pitch_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pitch_ff     <= pitch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      gy_ff        <= gy_in;
      product_ff   <= product_in;
      obs_ff       <= obs_in;
      est_ff       <= est_in;
      rsp_pitch_ff <= rsp_pitch_in;
      rsp_obs_ff   <= rsp_obs_in;
      rsp_est_ff   <= rsp_est_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_pitch_angle     = rsp_pitch_ff;
   assign rsp_observed_angle  = rsp_obs_ff;
   assign rsp_estimated_angle = rsp_est_ff;

   a_idle_unit_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !cordic_status.busy)
      else $error("sequencer idle while cordic still busy");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (cordic_status.busy && (state_ff == ST_CORDIC)))
      else $error("accepted transaction did not start the cordic");

   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_pitch_ff <= 17'sd46080) && (rsp_pitch_ff >= -17'sd46080)
                        && (rsp_est_ff <= 17'sd46080) && (rsp_est_ff >= -17'sd46080)))
      else $error("response angle outside +-180 degrees");

endmodule

// ===== tb/tb.sv =====
module tb;
   import pcf_pkg::*;

   localparam int     CLOCK_HALF       = 5;
   localparam int     RESET_CYCLES     = 8;
   // cycles without any transaction on any channel before the run is abandoned
   localparam int     QUIET_LIMIT      = 2000;
   // settle time after the last response, longer than the accept-to-response latency
   localparam int     SETTLE_CYCLES    = 40;
   localparam int     RANDOM_PER_PHASE = 400;
   localparam int     TILT_STEPS       = 16;
   localparam longint HALF_TURN        = 11796480;
   localparam longint GAIN_ROUND       = 8388608;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   typedef struct packed {
      logic signed [ANGLE_W-1:0] pitch;
      logic signed [ANGLE_W-1:0] observed;
      logic signed [ANGLE_W-1:0] estimated;
   } pitch_result_type;

   // one row of the directed table: either a register write or a sample set,
   // with the response typed in where it is obvious
   typedef struct packed {
      logic                           is_write;
      logic [CSR_IDX_W-1:0]           index;
      logic [CSR_DATA_W-1:0]          data;
      logic signed [SAMPLE_WIDTH-1:0] accel_x;
      logic signed [SAMPLE_WIDTH-1:0] accel_z;
      logic signed [SAMPLE_WIDTH-1:0] gyro_y;
      logic                           typed;
      pitch_result_type               want;
   } stimulus_row_type;

   logic                           clock     = 1'b0;
   logic                           reset     = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic signed [SAMPLE_WIDTH-1:0] req_accel_x = '0;
   logic signed [SAMPLE_WIDTH-1:0] req_accel_z = '0;
   logic signed [SAMPLE_WIDTH-1:0] req_gyro_y  = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic signed [ANGLE_W-1:0]      rsp_pitch_angle;
   logic signed [ANGLE_W-1:0]      rsp_observed_angle;
   logic signed [ANGLE_W-1:0]      rsp_estimated_angle;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [CSR_IDX_W-1:0]           csr_index = '0;
   logic [CSR_DATA_W-1:0]          csr_data  = '0;

   // predictor copy of the registers and the stored pitch
   logic signed [SAMPLE_WIDTH-1:0] accel_offset_model = '0;
   logic signed [SAMPLE_WIDTH-1:0] gyro_offset_model  = '0;
   logic [GAIN_W-1:0]              gain_model         = GAIN_W'(65536);
   logic signed [ANGLE_W-1:0]      pitch_model        = '0;

   // atan(2^-i) in 1/65536 degree
   longint tilt_step_angle [0:TILT_STEPS-1] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115
   };

   pitch_result_type pitch_expect_q [$];
   stimulus_row_type directed_rows [$];

   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int mismatch_count = 0;
   int quiet_cycles = 0;

   pitch_complementary_filter dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_accel_x         (req_accel_x),
      .req_accel_z         (req_accel_z),
      .req_gyro_y          (req_gyro_y),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_pitch_angle     (rsp_pitch_angle),
      .rsp_observed_angle  (rsp_observed_angle),
      .rsp_estimated_angle (rsp_estimated_angle),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   function automatic longint clamp_angle(input longint v);
      if (v > ANGLE_MAX) return ANGLE_MAX;
      if (v < -ANGLE_MAX) return -ANGLE_MAX;
      return v;
   endfunction

   // accelerometer pitch atan2(-ax, az) by shift-add vectoring, 1/256 degree
   function automatic longint tilt_angle(input longint ax, input longint az);
      longint x;
      longint y;
      longint z;
      longint xs;
      longint ys;
      int     i;
      x = az * 256;
      y = -ax * 256;
      z = 0;
      if (x == 0 && y == 0) return 0;
      // fold the left half plane onto the right one, starting from +-180 degrees
      if (x < 0) begin
         z = (y >= 0) ? HALF_TURN : -HALF_TURN;
         x = -x;
         y = -y;
      end
      for (i = 0; i < TILT_STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            z = z + tilt_step_angle[i];
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - tilt_step_angle[i];
         end
      end
      return clamp_angle((z + 128) >>> 8);
   endfunction

   // fuse one sample set into the stored pitch and return the response
   task automatic advance_filter(input logic signed [SAMPLE_WIDTH-1:0] ax_raw,
                                 input logic signed [SAMPLE_WIDTH-1:0] az_raw,
                                 input logic signed [SAMPLE_WIDTH-1:0] gy_raw,
                                 output pitch_result_type r);
      longint ax;
      longint gy;
      longint obs;
      longint est;
      longint delta;
      ax    = longint'(ax_raw) - longint'(accel_offset_model);
      gy    = longint'(gy_raw) - longint'(gyro_offset_model);
      obs   = tilt_angle(ax, longint'(az_raw));
      delta = (gy * longint'(gain_model) + GAIN_ROUND) >>> 24;
      est   = clamp_angle(longint'(pitch_model) + delta);
      pitch_model = ANGLE_W'(clamp_angle((obs + est + 1) >>> 1));
      r.pitch     = pitch_model;
      r.observed  = ANGLE_W'(obs);
      r.estimated = ANGLE_W'(est);
   endtask

   // ---------------------------------------------------------------------
   // Drivers: change inputs on the falling edge, look at handshakes on the
   // rising edge
   // ---------------------------------------------------------------------

   // drop the request and hold until every queued response has come back
   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pitch_expect_q.size() != 0) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      wait_for_results();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_ACCEL_X_OFFSET: accel_offset_model = data[SAMPLE_WIDTH-1:0];
         CSR_GYRO_Y_OFFSET:  gyro_offset_model  = data[SAMPLE_WIDTH-1:0];
         CSR_GYRO_STEP_GAIN: gain_model         = data[GAIN_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // offer one sample set; a typed response, when given, replaces the
   // predicted one, while the predictor still advances its stored pitch
   task automatic drive_sample(input logic signed [SAMPLE_WIDTH-1:0] ax,
                               input logic signed [SAMPLE_WIDTH-1:0] az,
                               input logic signed [SAMPLE_WIDTH-1:0] gy,
                               input logic typed,
                               input pitch_result_type typed_result);
      pitch_result_type predicted;
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         // idle with junk on the payload
         req_valid   <= 1'b0;
         req_accel_x <= SAMPLE_WIDTH'($urandom);
         req_accel_z <= SAMPLE_WIDTH'($urandom);
         req_gyro_y  <= SAMPLE_WIDTH'($urandom);
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_accel_x <= ax;
      req_accel_z <= az;
      req_gyro_y  <= gy;
      do @(posedge clock); while (req_stall);
      advance_filter(ax, az, gy, predicted);
      pitch_expect_q.push_back(typed ? typed_result : predicted);
   endtask

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   // ---------------------------------------------------------------------
   // Response check
   // ---------------------------------------------------------------------

   function automatic void check_field(input string name,
                                       input logic signed [ANGLE_W-1:0] want,
                                       input logic signed [ANGLE_W-1:0] got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin : response_monitor
      pitch_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pitch_expect_q.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected response pitch %0d observed %0d estimated %0d",
                     $time, rsp_pitch_angle, rsp_observed_angle, rsp_estimated_angle);
         end else begin
            want = pitch_expect_q.pop_front();
            check_field("pitch_angle", want.pitch, rsp_pitch_angle);
            check_field("observed_angle", want.observed, rsp_observed_angle);
            check_field("estimated_angle", want.estimated, rsp_estimated_angle);
         end
      end
   end

   // abandon the run once no channel has moved a transaction for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Directed table
   // ---------------------------------------------------------------------

   function automatic void add_sample(input logic signed [SAMPLE_WIDTH-1:0] ax,
                                      input logic signed [SAMPLE_WIDTH-1:0] az,
                                      input logic signed [SAMPLE_WIDTH-1:0] gy);
      stimulus_row_type row;
      row = '0;
      row.accel_x = ax;
      row.accel_z = az;
      row.gyro_y  = gy;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_checked(input logic signed [SAMPLE_WIDTH-1:0] ax,
                                       input logic signed [SAMPLE_WIDTH-1:0] az,
                                       input logic signed [SAMPLE_WIDTH-1:0] gy,
                                       input logic signed [ANGLE_W-1:0] pitch,
                                       input logic signed [ANGLE_W-1:0] observed,
                                       input logic signed [ANGLE_W-1:0] estimated);
      stimulus_row_type row;
      row = '0;
      row.accel_x        = ax;
      row.accel_z        = az;
      row.gyro_y         = gy;
      row.typed          = 1'b1;
      row.want.pitch     = pitch;
      row.want.observed  = observed;
      row.want.estimated = estimated;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_write(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] data);
      stimulus_row_type row;
      row = '0;
      row.is_write = 1'b1;
      row.index    = idx;
      row.data     = data;
      directed_rows.push_back(row);
   endfunction

   function automatic logic signed [SAMPLE_WIDTH-1:0] pick_extreme();
      case ($urandom_range(4))
         0:       return -32768;
         1:       return 32767;
         2:       return 0;
         3:       return -1;
         default: return 1;
      endcase
   endfunction

   // random sample set: mostly full range, plus level-ish attitudes, zero X
   // after the offset, extremes and tiny values
   task automatic pick_sample(output logic signed [SAMPLE_WIDTH-1:0] ax,
                              output logic signed [SAMPLE_WIDTH-1:0] az,
                              output logic signed [SAMPLE_WIDTH-1:0] gy);
      case ($urandom_range(9))
         5, 6: begin
            ax = SAMPLE_WIDTH'($urandom_range(30000) - 15000);
            az = SAMPLE_WIDTH'($urandom_range(20000, 12000));
            if ($urandom_range(1)) az = -az;
            gy = SAMPLE_WIDTH'($urandom_range(4000) - 2000);
         end
         7: begin
            // X cancels against its offset: zero vector or straight up/down
            ax = accel_offset_model;
            case ($urandom_range(2))
               0:       az = 0;
               1:       az = SAMPLE_WIDTH'(-$urandom_range(32768, 1));
               default: az = SAMPLE_WIDTH'($urandom_range(32767, 1));
            endcase
            gy = SAMPLE_WIDTH'($urandom);
         end
         8: begin
            ax = pick_extreme();
            az = pick_extreme();
            gy = pick_extreme();
         end
         9: begin
            ax = SAMPLE_WIDTH'($urandom_range(6) - 3);
            az = SAMPLE_WIDTH'($urandom_range(6) - 3);
            gy = SAMPLE_WIDTH'($urandom_range(6) - 3);
         end
         default: begin
            ax = SAMPLE_WIDTH'($urandom);
            az = SAMPLE_WIDTH'($urandom);
            gy = SAMPLE_WIDTH'($urandom);
         end
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------

   initial begin : main_sequence
      logic signed [SAMPLE_WIDTH-1:0] ax;
      logic signed [SAMPLE_WIDTH-1:0] az;
      logic signed [SAMPLE_WIDTH-1:0] gy;
      int                             n;
      int                             phase;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset registers: zero offsets, gain of one LSB per 256 gyro LSB
      add_checked(0, 0, 0, 0, 0, 0);                  // zero vector
      add_checked(0, -32768, 0, 23040, 46080, 0);     // straight down: +180 degrees
      add_sample(0, -1, 0);                           // straight down, smallest scale
      add_sample(32767, 0, 0);                        // -90 degrees
      add_sample(-32768, 0, 0);                       // +90 degrees
      add_sample(-32768, -32768, -32768);
      add_sample(32767, 32767, 32767);
      add_sample(1, -32768, 0);                       // just below the -180 fold
      add_sample(-1, -32768, 0);                      // just above the +180 fold
      // largest gain: drive the gyro estimate into both limits
      add_write(CSR_GYRO_STEP_GAIN, 24'hFFFFFF);
      add_sample(0, 100, 32767);
      add_sample(0, 100, 32767);
      add_sample(0, 100, -32768);
      add_sample(0, 100, -32768);
      // extreme offsets: differences reach the full 17-bit span
      add_write(CSR_ACCEL_X_OFFSET, 24'hA58000);
      add_write(CSR_GYRO_Y_OFFSET, 24'h3C7FFF);
      add_sample(32767, 5, -32768);
      add_write(CSR_ACCEL_X_OFFSET, 24'h5A7FFF);
      add_write(CSR_GYRO_Y_OFFSET, 24'hFF8000);
      add_sample(-32768, -5, 32767);
      add_sample(32767, 0, 0);                        // zero vector after the offset
      add_write(CSR_UNMAPPED, 24'hFFFFFF);            // must be ignored
      add_write(CSR_GYRO_STEP_GAIN, 24'h000000);      // gyro has no effect
      add_sample(1000, 1000, 1234);
      add_sample(32767, -200, -32768);                // straight down after the offset

      foreach (directed_rows[k]) begin
         if (directed_rows[k].is_write) begin
            write_register(directed_rows[k].index, directed_rows[k].data);
         end else begin
            drive_sample(directed_rows[k].accel_x, directed_rows[k].accel_z,
                         directed_rows[k].gyro_y, directed_rows[k].typed,
                         directed_rows[k].want);
         end
      end

      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               // sender mostly active, receiver mostly stalled; small offsets, reset gain
               sender_idle_pct    = 24;
               receiver_stall_pct = 78;
               write_register(CSR_ACCEL_X_OFFSET, {8'($urandom),
                              16'($urandom_range(400) - 200)});
               write_register(CSR_GYRO_Y_OFFSET, {8'($urandom),
                              16'($urandom_range(400) - 200)});
               write_register(CSR_GYRO_STEP_GAIN, GAIN_W'(65536));
            end
            1: begin
               // sender mostly idle, receiver mostly ready; anything goes
               sender_idle_pct    = 78;
               receiver_stall_pct = 24;
               write_register(CSR_ACCEL_X_OFFSET, CSR_DATA_W'($urandom));
               write_register(CSR_GYRO_Y_OFFSET, CSR_DATA_W'($urandom));
               write_register(CSR_GYRO_STEP_GAIN, CSR_DATA_W'($urandom));
            end
            default: begin
               // back to back; zero offsets, moderate gain
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
               write_register(CSR_ACCEL_X_OFFSET, {8'($urandom), 16'h0000});
               write_register(CSR_GYRO_Y_OFFSET, {8'($urandom), 16'h0000});
               write_register(CSR_GYRO_STEP_GAIN, GAIN_W'($urandom_range(1 << 20)));
            end
         endcase
         for (n = 0; n < RANDOM_PER_PHASE; n++) begin
            pick_sample(ax, az, gy);
            drive_sample(ax, az, gy, 1'b0, '0);
            // hold the sender now and then until the block has drained
            if (n % 150 == 75) wait_for_results();
         end
      end

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
